>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/ssscan_pkg.sv
// ----------------------------------------------------------------------------
// ssscan_pkg
// Shared constants, codes and types of the selective state scan block.
// ----------------------------------------------------------------------------
package ssscan_pkg;

   // default sizes of the hidden store
   localparam int MAX_CHANNELS_DEF = 1024;
   localparam int MAX_STATES_DEF   = 16;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATES   = 1'b1;
   localparam logic [10:0] CHAN_CFG_RESET  = 11'd1024;
   localparam logic [4:0]  STATE_CFG_RESET = 5'd16;

   // binary32 constants
   localparam logic [31:0] F32_ZERO        = 32'h0000_0000;
   localparam logic [31:0] F32_NEG_ZERO    = 32'h8000_0000;
   localparam logic [31:0] F32_DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] F32_INF         = 32'h7F80_0000;
   localparam logic [31:0] F32_QUIET_BIT   = 32'h0040_0000;

   // operation tags carried through the fma pipeline
   localparam logic [1:0] TAG_SKIP = 2'd0;
   localparam logic [1:0] TAG_HID  = 2'd1;
   localparam logic [1:0] TAG_ACC  = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [1:0] tag;
   } fma_ctl_type;

endpackage

>>> design/selective_state_scan.sv
// ----------------------------------------------------------------------------
// selective_state_scan
// Streaming selective state-space scan core on binary32 values.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel, one per (channel, state index), state
// index inner. Each request updates its stored hidden value with a fused
// multiply-add and folds hidden*readout_coef into the channel accumulator.
// After the last state index of a channel one result (y, channel, last flag)
// leaves on the rsp_ channel. A request is taken when valid is high and stall
// is low on its channel. csr_ writes set channels and states in use; write
// them only while the block is idle.
// Each request passes through one hidden-store read, then two dependent passes
// through the eight-stage fma pipeline (hidden update, then accumulate) before
// the next request is taken; the skip product overlaps the read. The result
// register holds a waiting result while the next request is taken; if the
// receiver still stalls when a channel closes, the block waits.
// After reset the hidden store is cleared one entry per cycle over all of its
// MAX_CHANNELS*MAX_STATES entries (16384 by default); req_stall stays high
// during that pass, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module selective_state_scan #(
   parameter int MAX_CHANNELS = ssscan_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_STATES   = ssscan_pkg::MAX_STATES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ssscan_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssscan_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [31:0]                      req_decay,
   input  logic [31:0]                      req_drive,
   input  logic [31:0]                      req_readout_coef,
   input  logic [31:0]                      req_channel_input,
   input  logic [31:0]                      req_skip_weight,
   input  logic                             req_start_sequence,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [31:0]                      rsp_y_value,
   output logic [9:0]                       rsp_channel_index,
   output logic                             rsp_last_of_step
);
   import ssscan_pkg::*;
`include "assert_macros.svh"

   localparam int DEPTH  = MAX_CHANNELS * MAX_STATES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ST_W   = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam logic [13:0] MAX_CH_LIM = 14'(MAX_CHANNELS);
   localparam logic [6:0]  MAX_ST_LIM = 7'(MAX_STATES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_HWAIT = 3'd3;
   localparam logic [2:0] ST_AWAIT = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]        state_ff;
   logic [ADDR_W-1:0] clear_addr_ff;
   logic [CH_W-1:0]   chan_ff;
   logic [ST_W-1:0]   sidx_ff;
   logic [10:0]       chan_cfg_ff;
   logic [4:0]        state_cfg_ff;
   logic [31:0]       decay_ff, drive_ff, coef_ff, acc_ff;
   logic              start_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   logic [31:0]       rsp_y_ff;
   logic [9:0]        rsp_chan_ff;

   logic              accept;
   logic [13:0]       nch;
   logic [6:0]        nst;
   logic              end_ch, last_ch, rsp_free, rsp_load;
   logic [ADDR_W-1:0] idx;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr;
   logic [31:0]       mem_wdata, mem_rdata;
   fma_ctl_type       fma_in_ctl, fma_out_ctl;
   logic [31:0]       fma_a, fma_b, fma_c, fma_res;
   logic              hid_done, acc_done;

   // effective limits, saturated into range
   always_comb begin
      if (chan_cfg_ff == '0) nch = 14'd1;
      else if (14'(chan_cfg_ff) > MAX_CH_LIM) nch = MAX_CH_LIM;
      else nch = 14'(chan_cfg_ff);
      if (state_cfg_ff == '0) nst = 7'd1;
      else if (7'(state_cfg_ff) > MAX_ST_LIM) nst = MAX_ST_LIM;
      else nst = 7'(state_cfg_ff);
   end

   assign end_ch   = (7'(sidx_ff) + 7'd1) >= nst;
   assign last_ch  = (14'(chan_ff) + 14'd1) >= nch;
   assign idx      = ADDR_W'(chan_ff) * ADDR_W'(MAX_STATES) + ADDR_W'(sidx_ff);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept   = req_valid && !req_stall;
   assign hid_done = fma_out_ctl.valid && (fma_out_ctl.tag == TAG_HID);
   assign acc_done = fma_out_ctl.valid && (fma_out_ctl.tag == TAG_ACC);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_EMIT) && end_ch && rsp_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cfg_ff  <= CHAN_CFG_RESET;
         state_cfg_ff <= STATE_CFG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHANNELS: chan_cfg_ff  <= csr_wr_data;
            CSR_STATES:   state_cfg_ff <= csr_wr_data[4:0];
            default: ;
         endcase
      end
   end

   // hidden store: clear pass, read on accept, write back the new hidden value
   assign mem_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_HWAIT) && hid_done);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clear_addr_ff : idx;
   assign mem_wdata = (state_ff == ST_CLEAR) ? F32_ZERO : fma_res;
   assign mem_re    = accept;

   ssscan_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_hidden_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (idx),
      .rd_data (mem_rdata)
   );

   // issue fma operations
   always_comb begin
      fma_in_ctl = '0;
      fma_a = req_skip_weight;
      fma_b = req_channel_input;
      fma_c = F32_NEG_ZERO;
      if (accept && (sidx_ff == '0)) begin
         fma_in_ctl = '{valid: 1'b1, tag: TAG_SKIP};
      end else if (state_ff == ST_READ) begin
         fma_in_ctl = '{valid: 1'b1, tag: TAG_HID};
         fma_a = decay_ff;
         fma_b = start_ff ? F32_ZERO : mem_rdata;
         fma_c = drive_ff;
      end else if ((state_ff == ST_HWAIT) && hid_done) begin
         fma_in_ctl = '{valid: 1'b1, tag: TAG_ACC};
         fma_a = fma_res;
         fma_b = coef_ff;
         fma_c = acc_ff;
      end
   end

   ssscan_fma u_fma (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (fma_in_ctl),
      .in_a       (fma_a),
      .in_b       (fma_b),
      .in_c       (fma_c),
      .out_ctl    (fma_out_ctl),
      .out_result (fma_res)
   );

   // hold request fields and the channel accumulator
   always_ff @(posedge clock) begin
      if (accept) begin
         decay_ff <= req_decay;
         drive_ff <= req_drive;
         coef_ff  <= req_readout_coef;
         start_ff <= req_start_sequence;
      end
      if (fma_out_ctl.valid &&
          (fma_out_ctl.tag == TAG_SKIP || fma_out_ctl.tag == TAG_ACC)) begin
         acc_ff <= fma_res;
      end
   end

   // sequencer and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         chan_ff       <= '0;
         sidx_ff       <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
               if (clear_addr_ff == LAST_ADDR) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_HWAIT;
            end
            ST_HWAIT: begin
               if (hid_done) state_ff <= ST_AWAIT;
            end
            ST_AWAIT: begin
               if (acc_done) state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!end_ch) begin
                  sidx_ff  <= sidx_ff + ST_W'(1);
                  state_ff <= ST_IDLE;
               end else if (rsp_free) begin
                  sidx_ff  <= '0;
                  chan_ff  <= last_ch ? '0 : chan_ff + CH_W'(1);
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_y_ff    <= acc_ff;
         rsp_chan_ff <= 10'(chan_ff);
         rsp_last_ff <= last_ch;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_y_value       = rsp_y_ff;
   assign rsp_channel_index = rsp_chan_ff;
   assign rsp_last_of_step  = rsp_last_ff;

   // hidden and accumulate results come back only where the sequencer waits
   `ASSERT_IMPLIES(a_hid_in_wait, clock, reset, hid_done, state_ff == ST_HWAIT)
   `ASSERT_IMPLIES(a_acc_in_wait, clock, reset, acc_done, state_ff == ST_AWAIT)
   // a store write never coincides with a new read
   `ASSERT_IMPLIES(a_no_rw_overlap, clock, reset, mem_we, !mem_re)
   // a loaded result is visible in the next cycle
   `ASSERT_NEXT(a_load_shows, clock, reset, rsp_load, rsp_valid)

endmodule

>>> design/ssscan_ram.sv
// ----------------------------------------------------------------------------
// ssscan_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssscan_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ssscan_fma.sv
// ----------------------------------------------------------------------------
// ssscan_fma
// Eight-stage binary32 fused multiply-add, round to nearest even, subnormals
// kept. Accepts one operation per cycle; a tag rides along with each one.
// ----------------------------------------------------------------------------
module ssscan_fma (
   input  logic                     clock,
   input  logic                     reset,
   input  ssscan_pkg::fma_ctl_type  in_ctl,
   input  logic [31:0]              in_a,
   input  logic [31:0]              in_b,
   input  logic [31:0]              in_c,
   output ssscan_pkg::fma_ctl_type  out_ctl,
   output logic [31:0]              out_result
);
   import ssscan_pkg::*;

   // position of the highest set bit
   function automatic logic [5:0] msb64(input logic [63:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

   // right shift that folds lost bits into bit zero
   function automatic logic [63:0] shr_sticky(input logic [63:0] v, input logic [11:0] d);
      logic [63:0] sh;
      sh = '0;
      if (d >= 12'd63) begin
         sh = {63'b0, |v};
      end else begin
         sh = v >> d[5:0];
         sh[0] = sh[0] | ((sh << d[5:0]) != v);
      end
      return sh;
   endfunction

   // control pipeline
   fma_ctl_type ctl_ff [8];

   // stage 1: unpack, special cases, mantissa product
   logic        sa, sb, sc, sp;
   logic [7:0]  ea, eb, ec, eae, ebe, ece;
   logic [22:0] fa, fb, fc;
   logic        ainf, binf, cinf, azero, bzero, czero;
   logic        spec;
   logic [31:0] spec_val;
   logic [23:0] ma, mb, mc;

   always_comb begin
      sa = in_a[31]; sb = in_b[31]; sc = in_c[31];
      ea = in_a[30:23]; eb = in_b[30:23]; ec = in_c[30:23];
      fa = in_a[22:0]; fb = in_b[22:0]; fc = in_c[22:0];
      sp = sa ^ sb;
      ainf = (ea == 8'hFF); binf = (eb == 8'hFF); cinf = (ec == 8'hFF);
      azero = (ea == 8'd0) && (fa == '0);
      bzero = (eb == 8'd0) && (fb == '0);
      czero = (ec == 8'd0) && (fc == '0);
      spec = 1'b1;
      spec_val = F32_ZERO;
      if (ainf && fa != '0) begin
         spec_val = in_a | F32_QUIET_BIT;
      end else if (binf && fb != '0) begin
         spec_val = in_b | F32_QUIET_BIT;
      end else if (cinf && fc != '0) begin
         spec_val = in_c | F32_QUIET_BIT;
      end else if (ainf || binf) begin
         if (azero || bzero) spec_val = F32_DEFAULT_NAN;
         else if (cinf && sc != sp) spec_val = F32_DEFAULT_NAN;
         else spec_val = {sp, F32_INF[30:0]};
      end else if (cinf) begin
         spec_val = in_c;
      end else if (azero || bzero) begin
         spec_val = czero ? {sp & sc, 31'b0} : in_c;
      end else begin
         spec = 1'b0;
      end
      ma  = {ea != 8'd0, fa};
      mb  = {eb != 8'd0, fb};
      mc  = {ec != 8'd0, fc};
      eae = (ea == 8'd0) ? 8'd1 : ea;
      ebe = (eb == 8'd0) ? 8'd1 : eb;
      ece = (ec == 8'd0) ? 8'd1 : ec;
   end

   logic [47:0] s1_prod_ff;
   logic [8:0]  s1_eab_ff;
   logic [23:0] s1_mc_ff;
   logic [7:0]  s1_ec_ff;
   logic        s1_czero_ff, s1_sp_ff, s1_sc_ff, s1_spec_ff;
   logic [31:0] s1_spec_val_ff;

   always_ff @(posedge clock) begin
      s1_prod_ff     <= ma * mb;
      s1_eab_ff      <= {1'b0, eae} + {1'b0, ebe};
      s1_mc_ff       <= mc;
      s1_ec_ff       <= ece;
      s1_czero_ff    <= czero;
      s1_sp_ff       <= sp;
      s1_sc_ff       <= sc;
      s1_spec_ff     <= spec;
      s1_spec_val_ff <= spec_val;
   end

   // stage 2: leading bit of both mantissas
   logic [47:0] s2_prod_ff;
   logic [8:0]  s2_eab_ff;
   logic [23:0] s2_mc_ff;
   logic [7:0]  s2_ec_ff;
   logic [5:0]  s2_px_ff, s2_py_ff;
   logic        s2_czero_ff, s2_sp_ff, s2_sc_ff, s2_spec_ff;
   logic [31:0] s2_spec_val_ff;

   always_ff @(posedge clock) begin
      s2_prod_ff     <= s1_prod_ff;
      s2_eab_ff      <= s1_eab_ff;
      s2_mc_ff       <= s1_mc_ff;
      s2_ec_ff       <= s1_ec_ff;
      s2_px_ff       <= msb64({16'b0, s1_prod_ff});
      s2_py_ff       <= msb64({40'b0, s1_mc_ff});
      s2_czero_ff    <= s1_czero_ff;
      s2_sp_ff       <= s1_sp_ff;
      s2_sc_ff       <= s1_sc_ff;
      s2_spec_ff     <= s1_spec_ff;
      s2_spec_val_ff <= s1_spec_val_ff;
   end

   // stage 3: normalize both operands to bit 61
   logic [5:0]         lsx, lsy;
   logic signed [11:0] ex_in, ey_in;
   logic [63:0]        x_in, y_in;

   always_comb begin
      lsx   = 6'd61 - s2_px_ff;
      lsy   = 6'd61 - s2_py_ff;
      x_in  = {16'b0, s2_prod_ff} << lsx;
      y_in  = s2_czero_ff ? 64'd0 : ({40'b0, s2_mc_ff} << lsy);
      ex_in = 12'(s2_eab_ff) - 12'd300 - 12'(lsx);
      ey_in = 12'(s2_ec_ff) - 12'd150 - 12'(lsy);
   end

   logic [63:0]        s3_x_ff, s3_y_ff;
   logic signed [11:0] s3_ex_ff, s3_ey_ff;
   logic               s3_czero_ff, s3_sp_ff, s3_sc_ff, s3_spec_ff;
   logic [31:0]        s3_spec_val_ff;

   always_ff @(posedge clock) begin
      s3_x_ff        <= x_in;
      s3_y_ff        <= y_in;
      s3_ex_ff       <= ex_in;
      s3_ey_ff       <= ey_in;
      s3_czero_ff    <= s2_czero_ff;
      s3_sp_ff       <= s2_sp_ff;
      s3_sc_ff       <= s2_sc_ff;
      s3_spec_ff     <= s2_spec_ff;
      s3_spec_val_ff <= s2_spec_val_ff;
   end

   // stage 4: align the smaller operand
   logic [63:0]        xa_in, ya_in;
   logic signed [11:0] e_in;

   always_comb begin
      if (s3_czero_ff || (s3_ex_ff >= s3_ey_ff)) begin
         xa_in = s3_x_ff;
         ya_in = shr_sticky(s3_y_ff, 12'(s3_ex_ff - s3_ey_ff));
         e_in  = s3_ex_ff;
      end else begin
         xa_in = shr_sticky(s3_x_ff, 12'(s3_ey_ff - s3_ex_ff));
         ya_in = s3_y_ff;
         e_in  = s3_ey_ff;
      end
   end

   logic [63:0]        s4_x_ff, s4_y_ff;
   logic signed [11:0] s4_e_ff;
   logic               s4_sp_ff, s4_sc_ff, s4_spec_ff;
   logic [31:0]        s4_spec_val_ff;

   always_ff @(posedge clock) begin
      s4_x_ff        <= xa_in;
      s4_y_ff        <= ya_in;
      s4_e_ff        <= e_in;
      s4_sp_ff       <= s3_sp_ff;
      s4_sc_ff       <= s3_sc_ff;
      s4_spec_ff     <= s3_spec_ff;
      s4_spec_val_ff <= s3_spec_val_ff;
   end

   // stage 5: add or subtract magnitudes
   logic [63:0] r_in;
   logic        s_in, cancel_in;

   always_comb begin
      cancel_in = 1'b0;
      if (s4_sp_ff == s4_sc_ff) begin
         r_in = s4_x_ff + s4_y_ff;
         s_in = s4_sp_ff;
      end else if (s4_x_ff > s4_y_ff) begin
         r_in = s4_x_ff - s4_y_ff;
         s_in = s4_sp_ff;
      end else if (s4_y_ff > s4_x_ff) begin
         r_in = s4_y_ff - s4_x_ff;
         s_in = s4_sc_ff;
      end else begin
         r_in = '0;
         s_in = 1'b0;
         cancel_in = 1'b1;
      end
   end

   logic [63:0]        s5_r_ff;
   logic signed [11:0] s5_e_ff;
   logic               s5_s_ff, s5_cancel_ff, s5_spec_ff;
   logic [31:0]        s5_spec_val_ff;

   always_ff @(posedge clock) begin
      s5_r_ff        <= r_in;
      s5_e_ff        <= s4_e_ff;
      s5_s_ff        <= s_in;
      s5_cancel_ff   <= cancel_in;
      s5_spec_ff     <= s4_spec_ff;
      s5_spec_val_ff <= s4_spec_val_ff;
   end

   // stage 6: leading bit of the sum
   logic [63:0]        s6_r_ff;
   logic [5:0]         s6_m_ff;
   logic signed [11:0] s6_e_ff;
   logic               s6_s_ff, s6_cancel_ff, s6_spec_ff;
   logic [31:0]        s6_spec_val_ff;

   always_ff @(posedge clock) begin
      s6_r_ff        <= s5_r_ff;
      s6_m_ff        <= msb64(s5_r_ff);
      s6_e_ff        <= s5_e_ff;
      s6_s_ff        <= s5_s_ff;
      s6_cancel_ff   <= s5_cancel_ff;
      s6_spec_ff     <= s5_spec_ff;
      s6_spec_val_ff <= s5_spec_val_ff;
   end

   // stage 7: shift to 24 bits, find guard and sticky
   logic signed [11:0] sha, shb, sh_in;
   logic [5:0]         amt;
   logic [63:0]        t;
   logic [23:0]        q_in;
   logic               guard, sticky, up_in;

   always_comb begin
      sha    = 12'(s6_m_ff) - 12'sd23;
      shb    = -12'sd149 - s6_e_ff;
      sh_in  = (shb > sha) ? shb : sha;
      amt    = '0;
      t      = '0;
      q_in   = '0;
      guard  = 1'b0;
      sticky = 1'b0;
      if (sh_in <= 12'sd0) begin
         amt  = 6'(-sh_in);
         t    = s6_r_ff << amt;
         q_in = t[23:0];
      end else if (sh_in < 12'sd64) begin
         amt    = 6'(sh_in - 12'sd1);
         t      = s6_r_ff >> amt;
         q_in   = t[24:1];
         guard  = t[0];
         sticky = ((t << amt) != s6_r_ff);
      end
      up_in = guard && (sticky || q_in[0]);
   end

   logic [23:0]        s7_q_ff;
   logic               s7_up_ff;
   logic signed [11:0] s7_sh_ff, s7_e_ff;
   logic               s7_s_ff, s7_cancel_ff, s7_spec_ff;
   logic [31:0]        s7_spec_val_ff;

   always_ff @(posedge clock) begin
      s7_q_ff        <= q_in;
      s7_up_ff       <= up_in;
      s7_sh_ff       <= sh_in;
      s7_e_ff        <= s6_e_ff;
      s7_s_ff        <= s6_s_ff;
      s7_cancel_ff   <= s6_cancel_ff;
      s7_spec_ff     <= s6_spec_ff;
      s7_spec_val_ff <= s6_spec_val_ff;
   end

   // stage 8: round, renormalize and pack
   logic [24:0]        qi;
   logic [23:0]        q2;
   logic signed [11:0] sh2, be;
   logic [31:0]        packed_val, res_in;

   always_comb begin
      qi  = {1'b0, s7_q_ff} + 25'(s7_up_ff);
      q2  = qi[24] ? qi[24:1] : qi[23:0];
      sh2 = qi[24] ? (s7_sh_ff + 12'sd1) : s7_sh_ff;
      be  = sh2 + s7_e_ff + 12'sd150;
      if (q2 == '0) begin
         packed_val = {s7_s_ff, 31'b0};
      end else if (!q2[23]) begin
         packed_val = {s7_s_ff, 8'd0, q2[22:0]};
      end else if (be >= 12'sd255) begin
         packed_val = {s7_s_ff, F32_INF[30:0]};
      end else begin
         packed_val = {s7_s_ff, be[7:0], q2[22:0]};
      end
      if (s7_spec_ff) res_in = s7_spec_val_ff;
      else if (s7_cancel_ff) res_in = F32_ZERO;
      else res_in = packed_val;
   end

   logic [31:0] s8_res_ff;

   always_ff @(posedge clock) begin
      s8_res_ff <= res_in;
   end

   // advance valid and tag alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int i = 1; i < 8; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   assign out_ctl    = ctl_ff[7];
   assign out_result = s8_res_ff;

endmodule

>>> bench/tb_selective_state_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_state_scan
// Self-checking bench for the selective state scan core: requests are driven
// through the req_ handshake while a scoreboard predicts each channel output
// with its own binary32 fused multiply-add, and results are checked in order.
// ----------------------------------------------------------------------------
import ssscan_pkg::*;

typedef struct {
   logic [31:0] decay;
   logic [31:0] drive;
   logic [31:0] coef;
   logic [31:0] u;
   logic [31:0] skip;
   logic        start;
} scan_req_type;

typedef struct {
   logic [31:0] y;
   logic [9:0]  chan;
   logic        last;
} chan_out_type;

class scan_scoreboard;
   localparam int NCH = MAX_CHANNELS_DEF;
   localparam int NST = MAX_STATES_DEF;

   logic [31:0]  hidden[NCH*NST];
   int           chan_cnt;
   int           state_cnt;
   logic [31:0]  acc;
   int           chan_cfg;
   int           state_cfg;
   chan_out_type outputs_due[$];
   int           errors;

   function new();
      foreach (hidden[i]) hidden[i] = F32_ZERO;
      chan_cnt = 0; state_cnt = 0; acc = F32_ZERO;
      chan_cfg = CHAN_CFG_RESET; state_cfg = STATE_CFG_RESET;
      errors = 0;
   endfunction

   function void write_cfg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_CHANNELS) chan_cfg = val & 11'h7FF;
      else state_cfg = val & 11'h1F;
   endfunction

   function int pending();
      return outputs_due.size();
   endfunction

   function int msb(bit [63:0] v);
      int p;
      p = 63;
      while (p > 0 && !v[p]) p--;
      return p;
   endfunction

   function bit [63:0] shift_sticky(bit [63:0] v, int d);
      if (d <= 0) return v;
      if (d >= 63) return (v != 0) ? 64'd1 : 64'd0;
      return (v >> d) | (((v & ((64'd1 << d) - 1)) != 0) ? 64'd1 : 64'd0);
   endfunction

   // round s * r * 2^e to binary32, nearest-even, subnormals kept
   function logic [31:0] round_f32(bit s, bit [63:0] r, int e);
      int        sh;
      int        be;
      bit [63:0] q;
      bit [63:0] rem;
      bit [63:0] half;
      sh = msb(r) - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh <= 0) q = r << (-sh);
      else if (sh >= 64) q = 0;
      else begin
         rem  = r & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         q    = r >> sh;
         if (rem > half || (rem == half && q[0])) q++;
      end
      if (q >= (64'd1 << 24)) begin
         q >>= 1;
         sh++;
      end
      if (q == 0) return {s, 31'd0};
      if (q < (64'd1 << 23)) return {s, q[30:0]};
      be = sh + e + 150;
      if (be >= 255) return {s, 31'd0} | F32_INF;
      return {s, be[7:0], q[22:0]};
   endfunction

   // a*b + c with one rounding
   function logic [31:0] fused_mac(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      bit          sa, sb, sc, sp, s;
      int          ea, eb, ec, ex, ey, e, p;
      bit [31:0]   fa, fb, fc;
      bit          ainf, binf, cinf, azero, bzero, czero;
      bit [63:0]   x, y, r;
      sa = a[31]; sb = b[31]; sc = c[31]; sp = sa ^ sb;
      ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
      fa = {9'd0, a[22:0]}; fb = {9'd0, b[22:0]}; fc = {9'd0, c[22:0]};
      ainf = ea == 255; binf = eb == 255; cinf = ec == 255;
      azero = ea == 0 && fa == 0; bzero = eb == 0 && fb == 0; czero = ec == 0 && fc == 0;
      // NaN operands propagate quieted, first one wins
      if (ainf && fa != 0) return a | F32_QUIET_BIT;
      if (binf && fb != 0) return b | F32_QUIET_BIT;
      if (cinf && fc != 0) return c | F32_QUIET_BIT;
      if (ainf || binf) begin
         if (azero || bzero) return F32_DEFAULT_NAN;
         if (cinf && sc != sp) return F32_DEFAULT_NAN;
         return {sp, 31'd0} | F32_INF;
      end
      if (cinf) return c;
      if (azero || bzero) begin
         if (czero) return {sp & sc, 31'd0};
         return c;
      end
      if (ea == 0) ea = 1; else fa |= 32'h80_0000;
      if (eb == 0) eb = 1; else fb |= 32'h80_0000;
      x = 64'(fa) * 64'(fb);
      p = msb(x);
      x <<= (61 - p);
      ex = ea + eb - 300 - (61 - p);
      if (czero) return round_f32(sp, x, ex);
      if (ec == 0) ec = 1; else fc |= 32'h80_0000;
      y = 64'(fc);
      p = msb(y);
      y <<= (61 - p);
      ey = ec - 150 - (61 - p);
      if (ex >= ey) begin
         y = shift_sticky(y, ex - ey);
         e = ex;
      end else begin
         x = shift_sticky(x, ey - ex);
         e = ey;
      end
      if (sp == sc) begin
         r = x + y; s = sp;
      end else if (x > y) begin
         r = x - y; s = sp;
      end else if (y > x) begin
         r = y - x; s = sc;
      end else begin
         return F32_ZERO;
      end
      return round_f32(s, r, e);
   endfunction

   // advance the predicted scan by one accepted request
   function void note_request(scan_req_type rq);
      int           nch, nst, idx;
      logic [31:0]  h;
      chan_out_type o;
      nch = chan_cfg; nst = state_cfg;
      if (nch < 1) nch = 1;
      if (nch > NCH) nch = NCH;
      if (nst < 1) nst = 1;
      if (nst > NST) nst = NST;
      if (chan_cnt >= NCH) chan_cnt = 0;
      if (state_cnt >= NST) state_cnt = NST - 1;
      idx = chan_cnt * NST + state_cnt;
      h = rq.start ? F32_ZERO : hidden[idx];
      h = fused_mac(rq.decay, h, rq.drive);
      hidden[idx] = h;
      if (state_cnt == 0) acc = fused_mac(rq.skip, rq.u, F32_NEG_ZERO);
      acc = fused_mac(h, rq.coef, acc);
      state_cnt++;
      if (state_cnt < nst) return;
      state_cnt = 0;
      o.y    = acc;
      o.chan = chan_cnt[9:0];
      o.last = (chan_cnt + 1 >= nch);
      chan_cnt = o.last ? 0 : chan_cnt + 1;
      outputs_due.push_back(o);
   endfunction

   function void check_result(logic [31:0] y, logic [9:0] chan, logic last);
      chan_out_type o;
      if (outputs_due.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("ERROR: unexpected result y=%h chan=%0d last=%b", y, chan, last);
         return;
      end
      o = outputs_due.pop_front();
      if (y !== o.y || chan !== o.chan || last !== o.last) begin
         errors++;
         if (errors <= 10)
            $display("ERROR: expected y=%h chan=%0d last=%b, got y=%h chan=%0d last=%b",
                     o.y, o.chan, o.last, y, chan, last);
      end
   endfunction
endclass

module tb_selective_state_scan;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_CHANNELS;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [31:0]           req_decay = '0;
   logic [31:0]           req_drive = '0;
   logic [31:0]           req_readout_coef = '0;
   logic [31:0]           req_channel_input = '0;
   logic [31:0]           req_skip_weight = '0;
   logic                  req_start_sequence = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [31:0]           rsp_y_value;
   logic [9:0]            rsp_channel_index;
   logic                  rsp_last_of_step;

   scan_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycles = 0;
   int nch_eff = 1;
   int nst_eff = 1;

   selective_state_scan DUT (.*);

   always #6 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // random receiver stall
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // check results between edges, where all signals are settled
   always @(negedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_y_value, rsp_channel_index, rsp_last_of_step);

   function automatic logic [31:0] rand_f32();
      logic [7:0] ex;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            ex = 8'($urandom_range(134, 118));
            return {1'($urandom), ex, 23'($urandom)};
         end
         5, 6: return $urandom;
         default: begin
            case ($urandom_range(9))
               0: return 32'h0000_0000;
               1: return 32'h8000_0000;
               2: return 32'h7F80_0000;
               3: return 32'hFF80_0000;
               4: return 32'h7FC0_0000;
               5: return 32'h7F80_0001;
               6: return 32'h0000_0001;
               7: return 32'h007F_FFFF;
               8: return 32'h7F7F_FFFF;
               default: return 32'h0080_0000;
            endcase
         end
      endcase
   endfunction

   // wait for every output, then let an open channel settle
   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // drive one register write; the caller drops the enable afterwards
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      sb.write_cfg(idx, val);
   endtask

   task automatic set_config(int ch, int st);
      req_valid <= 1'b0;
      wait_idle();
      write_csr(CSR_CHANNELS, CSR_DATA_W'(ch));
      write_csr(CSR_STATES, CSR_DATA_W'(st));
      csr_wr_en <= 1'b0;
      nch_eff = (ch < 1) ? 1 : (ch > MAX_CHANNELS_DEF ? MAX_CHANNELS_DEF : ch);
      nst_eff = (st < 1) ? 1 : (st > MAX_STATES_DEF ? MAX_STATES_DEF : st);
   endtask

   // drive one request and hold it until the block takes it
   task automatic send_request(scan_req_type rq);
      int  gap;
      bit  taken;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_decay          <= rq.decay;
      req_drive          <= rq.drive;
      req_readout_coef   <= rq.coef;
      req_channel_input  <= rq.u;
      req_skip_weight    <= rq.skip;
      req_start_sequence <= rq.start;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      sb.note_request(rq);
   endtask

   task automatic send_fields(logic [31:0] dc, logic [31:0] dr, logic [31:0] cf,
                              logic [31:0] u, logic [31:0] sk, logic st);
      scan_req_type rq;
      rq.decay = dc; rq.drive = dr; rq.coef = cf; rq.u = u; rq.skip = sk; rq.start = st;
      send_request(rq);
   endtask

   // random requests: start flag set through the first time step, then at random
   task automatic random_phase(int n);
      scan_req_type rq;
      for (int i = 0; i < n; i++) begin
         rq.decay = rand_f32();
         rq.drive = rand_f32();
         rq.coef  = rand_f32();
         rq.u     = rand_f32();
         rq.skip  = rand_f32();
         rq.start = (i < nch_eff * nst_eff) ? 1'b1 : ($urandom_range(19) == 0);
         send_request(rq);
      end
   endtask

   initial begin
      int cfg_ch[9]  = '{1, 3, 2, 4, 0, 2047, 1024, 5, 1};
      int cfg_st[9]  = '{1, 4, 16, 3, 0, 31, 1, 2, 16};
      int cfg_n[9]   = '{50, 60, 48, 50, 30, 34, 24, 60, 48};
      int pct_tx[4]  = '{0, 70, 0, 30};
      int pct_rx[4]  = '{0, 0, 70, 30};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: two channels of two states
      set_config(2, 2);
      send_fields(32'h3F00_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000,
                  32'h3F80_0000, 1'b1);
      send_fields(32'h3F00_0000, 32'hBF80_0000, 32'h4000_0000, 32'h0000_0000,
                  32'h0000_0000, 1'b1);
      // exact cancellation: skip 2.0 plus h(-2.0) * 1.0
      send_fields(32'h3F80_0000, 32'hC000_0000, 32'h3F80_0000, 32'h4000_0000,
                  32'h3F80_0000, 1'b1);
      send_fields(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000, 1'b1);
      // invalid: infinity times zero in the hidden update
      send_fields(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
                  32'h3F80_0000, 1'b1);
      // negative infinite drive; the infinite skip weight is unused at this state index
      send_fields(32'h3F80_0000, 32'hFF80_0000, 32'h3F80_0000, 32'h3F80_0000,
                  32'h7F80_0000, 1'b1);
      // NaN operands, signaling and quiet, order of precedence
      send_fields(32'h7F80_0001, 32'hFFC0_0001, 32'h3F80_0000, 32'h3F80_0000,
                  32'h3F80_0000, 1'b0);
      send_fields(32'h3F80_0000, 32'h7FA0_0000, 32'h7F80_0001, 32'hFF80_0001,
                  32'h3F80_0000, 1'b0);
      // all ones, then zeros of both signs
      send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 1'b1);
      send_fields(32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h0000_0000, 1'b0);
      // subnormals and overflow
      send_fields(32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'h0000_0003,
                  32'h0000_0001, 1'b1);
      send_fields(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
                  32'h7F7F_FFFF, 1'b0);
      // stored hidden value carried into a later step
      send_fields(32'h3F40_0000, 32'h3E80_0000, 32'hBF80_0000, 32'h4040_0000,
                  32'hBF00_0000, 1'b0);
      send_fields(32'h3F40_0000, 32'h3E80_0000, 32'h3FC0_0000, 32'h4040_0000,
                  32'hBF00_0000, 1'b0);
      send_fields(32'h3F70_0000, 32'hC100_0000, 32'h3F80_0000, 32'h4120_0000,
                  32'h3DCC_CCCD, 1'b0);
      send_fields(32'h3F70_0000, 32'hC100_0000, 32'h3F80_0000, 32'h4120_0000,
                  32'h3DCC_CCCD, 1'b0);
      // even item count: next config change lands on a step boundary

      // random phases over several settings and idle patterns
      for (int p = 0; p < 9; p++) begin
         set_config(cfg_ch[p], cfg_st[p]);
         send_idle_pct  = pct_tx[p % 4];
         recv_stall_pct = pct_rx[p % 4];
         random_phase(cfg_n[p] / 2);
         // hold off until every due output has been checked
         if (p == 3) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         random_phase(cfg_n[p] - cfg_n[p] / 2);
      end

      req_valid <= 1'b0;
      wait_idle();
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
